// ===== hdl/mhcs_pkg.sv =====
// Package: shared constants for the Hamiltonian cycle search unit.
package mhcs_pkg;
  localparam int MaxVertices = 8;
  localparam int WeightBits = 16;
  localparam int VtxBits = 3;
  localparam int CountBits = 4;
  localparam int CostBits = 20;
  localparam logic [CostBits-1:0] CostMax = '1;
  localparam logic OpLoad = 1'b0;
  localparam logic OpStart = 1'b1;
endpackage

// ===== hdl/mhcs_acc.sv =====
// Shared saturating cost accumulator: one edge weight added per cycle while add_i is high.
module mhcs_acc #(
  parameter int WeightBits = mhcs_pkg::WeightBits
) (
  input  logic                          clk_i,
  input  logic                          clear_i,
  input  logic                          add_i,
  input  logic [WeightBits-1:0]         weight_i,
  output logic [mhcs_pkg::CostBits-1:0] sum_o
);
  localparam int SumW = (mhcs_pkg::CostBits > WeightBits ? mhcs_pkg::CostBits : WeightBits) + 1;
  logic [mhcs_pkg::CostBits-1:0] sum_q, sum_d;
  logic [SumW-1:0] wide;

  always_comb begin
    wide = SumW'(sum_q) + SumW'(weight_i);
    sum_d = sum_q;
    if (clear_i) begin
      sum_d = '0;
    end else if (add_i) begin
      sum_d = (wide > SumW'(mhcs_pkg::CostMax)) ? mhcs_pkg::CostMax
                                                : wide[mhcs_pkg::CostBits-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;
endmodule

// ===== hdl/min_hamiltonian_cycle_search_unit.sv =====
// Top level: brute-force minimum Hamiltonian cycle search over a loaded weight matrix.
// Load beats are accepted back to back, one per cycle. A start beat enters an init state, then per
// order with vertex 0 first: costing (matrix read, then add in the shared adder, per edge), a
// compare step and next-order stepping (find i, find j, swap, reverse); then n+1 result beats
// (one if no cycle), each held until m_axis_tready.
// Ready is low from the start beat until the last result beat is accepted.
// Reset (rst_ni low, async) clears control, vertex_count to 8; matrix is undefined.
module min_hamiltonian_cycle_search_unit #(
  parameter int WeightBits  = mhcs_pkg::WeightBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,           // vertex_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [0:0]  s_axis_tuser,          // operation
  input  logic [23:0] s_axis_tdata,          // row[2:0], col[5:3], weight[21:6], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [0:0]  m_axis_tuser,          // found
  output logic        m_axis_tlast,
  output logic [23:0] m_axis_tdata           // min_cost[19:0], vertex[22:20], zero pad
);
  localparam int MaxVertices = mhcs_pkg::MaxVertices;
  localparam int VB = $clog2(MaxVertices);
  localparam int CB = $clog2(MaxVertices + 1);
  localparam int AB = 2 * VB;
  localparam int Depth = MaxVertices * MaxVertices;
  localparam int CostBits = mhcs_pkg::CostBits;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_RD, S_ACC, S_EVAL, S_FINDI, S_FINDJ, S_SWAP, S_REV, S_OUT
  } state_e;

  state_e state_q;
  logic [CB-1:0] vcnt_q, n_q;
  logic [VB-1:0] ord_q [MaxVertices];
  logic [VB-1:0] best_q [MaxVertices];
  logic [CostBits-1:0] bcost_q;
  logic seen_q, zero_q;
  logic [CB-1:0] k_q;
  logic [CB-1:0] i_q, j_q, lo_q, hi_q;
  logic [WeightBits-1:0] mem [Depth];
  logic [WeightBits-1:0] rd_q;
  logic [AB-1:0] rd_addr;
  logic acc_clr, acc_add;
  logic [CostBits-1:0] sum;
  logic [CB-1:0] nxt;
  logic [VB-1:0] row, col, va, vb;
  logic s_fire, m_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign m_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign row = s_axis_tdata[VB-1:0];
  assign col = s_axis_tdata[3+VB-1:3];

  // Address of edge ord[k] -> ord[(k+1) mod n].
  always_comb begin
    nxt = (k_q + 1'b1 == n_q) ? '0 : k_q + 1'b1;
    va = ord_q[k_q[VB-1:0]];
    vb = ord_q[nxt[VB-1:0]];
    rd_addr = {va, vb};
  end

  // Weight matrix: written by load beats, read once a cycle during costing.
  always_ff @(posedge clk_i) begin
    if (s_fire && s_axis_tuser[0] == mhcs_pkg::OpLoad &&
        {1'b0, s_axis_tdata[2:0]} < 4'(MaxVertices) &&
        {1'b0, s_axis_tdata[5:3]} < 4'(MaxVertices)) begin
      mem[{row, col}] <= WeightBits'(s_axis_tdata[21:6]);
    end
    rd_q <= mem[rd_addr];
  end

  assign acc_clr = (state_q == S_RD) && (k_q == '0);
  assign acc_add = (state_q == S_ACC);

  mhcs_acc #(.WeightBits(WeightBits)) u_acc (
    .clk_i, .clear_i(acc_clr), .add_i(acc_add), .weight_i(rd_q), .sum_o(sum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q <= CB'(MaxVertices);
      n_q <= CB'(MaxVertices);
      seen_q <= 1'b0;
      zero_q <= 1'b0;
      bcost_q <= mhcs_pkg::CostMax;
      k_q <= '0; i_q <= '0; j_q <= '0; lo_q <= '0; hi_q <= '0;
      for (int v = 0; v < MaxVertices; v++) begin
        ord_q[v] <= VB'(v);
        best_q[v] <= VB'(v);
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i < 4'd2) vcnt_q <= CB'(2);
        else if ({1'b0, cfg_wdata_i} > 5'(MaxVertices)) vcnt_q <= CB'(MaxVertices);
        else vcnt_q <= CB'(cfg_wdata_i);
      end
      case (state_q)
        S_IDLE: begin
          if (s_fire && s_axis_tuser[0] == mhcs_pkg::OpStart) begin
            state_q <= S_INIT;
            n_q <= vcnt_q;
          end
        end
        S_INIT: begin
          for (int v = 0; v < MaxVertices; v++) begin
            ord_q[v] <= VB'(v);
            best_q[v] <= VB'(v);
          end
          bcost_q <= mhcs_pkg::CostMax;
          seen_q <= 1'b0;
          k_q <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          zero_q <= (k_q == '0) ? 1'b0 : zero_q;
          state_q <= S_ACC;
        end
        S_ACC: begin
          // rd_q holds weight of edge k; accumulator adds it this edge.
          if (rd_q == '0) zero_q <= 1'b1;
          if (k_q == n_q - 1'b1) begin
            state_q <= S_EVAL;
          end else begin
            k_q <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_EVAL: begin
          if (!zero_q && (!seen_q || sum < bcost_q)) begin
            bcost_q <= sum;
            seen_q <= 1'b1;
            for (int v = 0; v < MaxVertices; v++) best_q[v] <= ord_q[v];
          end
          i_q <= n_q - CB'(2);
          state_q <= S_FINDI;
        end
        S_FINDI: begin
          // Find largest i >= 1 with ord[i] < ord[i+1].
          if (i_q == '0) begin
            k_q <= '0;
            state_q <= S_OUT;
          end else if (ord_q[i_q[VB-1:0]] < ord_q[VB'(i_q + 1'b1)]) begin
            j_q <= n_q - 1'b1;
            state_q <= S_FINDJ;
          end else begin
            i_q <= i_q - 1'b1;
          end
        end
        S_FINDJ: begin
          if (ord_q[j_q[VB-1:0]] > ord_q[i_q[VB-1:0]]) state_q <= S_SWAP;
          else j_q <= j_q - 1'b1;
        end
        S_SWAP: begin
          ord_q[i_q[VB-1:0]] <= ord_q[j_q[VB-1:0]];
          ord_q[j_q[VB-1:0]] <= ord_q[i_q[VB-1:0]];
          lo_q <= i_q + 1'b1;
          hi_q <= n_q - 1'b1;
          state_q <= S_REV;
        end
        S_REV: begin
          if (lo_q < hi_q) begin
            ord_q[lo_q[VB-1:0]] <= ord_q[hi_q[VB-1:0]];
            ord_q[hi_q[VB-1:0]] <= ord_q[lo_q[VB-1:0]];
            lo_q <= lo_q + 1'b1;
            hi_q <= hi_q - 1'b1;
          end else begin
            k_q <= '0;
            state_q <= S_RD;
          end
        end
        S_OUT: begin
          if (m_fire) begin
            if (m_axis_tlast) state_q <= S_IDLE;
            else k_q <= k_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result beat k: best_order[k], closing beat repeats vertex 0.
  logic [VB-1:0] out_v;
  assign out_v = (k_q == n_q) ? best_q[0] : best_q[k_q[VB-1:0]];
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tuser = seen_q;
  assign m_axis_tlast = !seen_q || (k_q == n_q);
  assign m_axis_tdata = seen_q ? {1'b0, 3'(out_v), bcost_q} : '0;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready during output");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && m_axis_tlast) |=> state_q == S_IDLE) else $error("no idle after last");
  a_nf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("bad not-found beat");
endmodule
